### hdl/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

	// Fixed-point setup
	localparam int FRAC_BITS_DEF = 8;
	localparam int GAIN_FRAC     = 8;
	localparam int GAIN_W        = 16;
	localparam int SPEED_W       = 8;
	localparam int COUNT_W       = 8;
	localparam int COUNT_MAX     = 255;

	// Steering limits
	localparam int SPEED_MIN   = 50;
	localparam int SPEED_MAX   = 200;
	localparam int PASS_SPEED  = 180;
	localparam int INTEG_LIMIT = 100;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_CROSS = 3'd4;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd2048;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd0;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd1024;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd125;
	localparam logic [COUNT_W-1:0] TARGET_CROSS_RST = 8'd1;

	// Result kinds
	typedef enum logic [1:0] {
		ACT_DRIVE = 2'd0,
		ACT_STOP  = 2'd1,
		ACT_PASS  = 2'd2
	} action_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Controller to datapath
	typedef struct packed {
		logic load_in;
		logic eval;
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic sum;
		logic speed;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic cross_evt;
	} sts_t;

endpackage

### hdl/lfps_ctrl.sv
`timescale 1ns / 1ps

module lfps_ctrl
	import lfps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EVAL  = 8'b0000_0010,
		ST_MUL_P = 8'b0000_0100,
		ST_MUL_I = 8'b0000_1000,
		ST_MUL_D = 8'b0001_0000,
		ST_SUM   = 8'b0010_0000,
		ST_SPEED = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q, state_nxt;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && s_tvalid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.mul_p    = (state_q == ST_MUL_P);
		cmd.mul_i    = (state_q == ST_MUL_I);
		cmd.mul_d    = (state_q == ST_MUL_D);
		cmd.sum      = (state_q == ST_SUM);
		cmd.speed    = (state_q == ST_SPEED);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// Advance through the evaluation sequence
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				state_nxt = sts.cross_evt ? ST_DONE : ST_MUL_P;
			end
			ST_MUL_P: state_nxt = ST_MUL_I;
			ST_MUL_I: state_nxt = ST_MUL_D;
			ST_MUL_D: state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_SPEED;
			ST_SPEED: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// Hold the word until taken
			if (cmd.load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/lfps_dp.sv
`timescale 1ns / 1ps

module lfps_dp
	import lfps_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_wr_t            cfg,
	input  logic [3:0]         sens,
	input  cmd_t               cmd,
	output sts_t               sts,
	output action_t            out_action,
	output logic [SPEED_W-1:0] out_left,
	output logic [SPEED_W-1:0] out_right,
	output logic [COUNT_W-1:0] out_count
);

	localparam int E_W = FRAC_BITS + 3;           // error
	localparam int Q_W = FRAC_BITS + 2;           // error magnitude
	localparam int I_W = FRAC_BITS + 8;           // integral, multiplier operand
	localparam int D_W = FRAC_BITS + 4;           // error difference
	localparam int P_W = FRAC_BITS + 25;          // product
	localparam int A_W = FRAC_BITS + 27;          // correction sum
	localparam int SH  = GAIN_FRAC + FRAC_BITS;   // speed scale

	localparam logic [Q_W-1:0] ERR_ONE   = Q_W'(1 << FRAC_BITS);
	localparam logic [Q_W-1:0] ERR_THIRD = Q_W'(((1 << (FRAC_BITS + 1)) + 3) / 6);

	localparam logic signed [I_W:0] INT_HI = (I_W+1)'(INTEG_LIMIT * (1 << FRAC_BITS));
	localparam logic signed [I_W:0] INT_LO = -INT_HI;

	localparam logic signed [A_W-1:0] V_LO = A_W'(SPEED_MIN) <<< SH;
	localparam logic signed [A_W-1:0] V_HI = A_W'(SPEED_MAX) <<< SH;

	// Configuration registers
	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [SPEED_W-1:0] base_speed_q;
	logic [COUNT_W-1:0] target_q;

	// Loop state
	logic signed [I_W-1:0] integ_q;
	logic signed [E_W-1:0] prev_err_q;
	logic                  on_cross_q;
	logic [COUNT_W-1:0]    count_q;

	// Work registers
	logic [3:0]            sens_q;
	logic signed [E_W-1:0] err_q;
	logic signed [D_W-1:0] diff_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [A_W-1:0] acc_q;
	action_t               res_action_q;
	logic [SPEED_W-1:0]    res_left_q, res_right_q;
	logic [COUNT_W-1:0]    res_count_q;
	action_t               out_action_q;
	logic [SPEED_W-1:0]    out_left_q, out_right_q;
	logic [COUNT_W-1:0]    out_count_q;

	// Sample classification
	logic [2:0]            n_act;
	logic                  cross_hit;
	logic                  cross_evt;
	logic [2:0]            w_pos, w_neg, mag;
	logic                  neg;
	logic [Q_W-1:0]        q;
	logic signed [E_W-1:0] q_s, err_new;
	logic signed [I_W:0]   integ_sum;
	logic signed [I_W-1:0] integ_nxt;
	logic [COUNT_W-1:0]    count_nxt;
	logic                  stop;

	// Multiplier and speeds
	logic [GAIN_W-1:0]     mul_a;
	logic signed [I_W-1:0] mul_b;
	logic signed [P_W-1:0] mul_y;
	logic signed [A_W-1:0] base_ext, v_left, v_right;

	function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [A_W-1:0] v);
		logic [SPEED_W-1:0] r;
		if (v < V_LO) r = SPEED_W'(SPEED_MIN);
		else if (v > V_HI) r = SPEED_W'(SPEED_MAX);
		else r = v[SH +: SPEED_W];
		return r;
	endfunction

	// Count active sensors and weigh the line position
	always_comb begin
		n_act = {2'b0, sens_q[0]} + {2'b0, sens_q[1]} + {2'b0, sens_q[2]} + {2'b0, sens_q[3]};
		cross_hit = n_act > 3'd2;
		cross_evt = cross_hit && !on_cross_q;
		w_pos = (sens_q[3] ? 3'd3 : 3'd0) + (sens_q[2] ? 3'd1 : 3'd0);
		w_neg = (sens_q[0] ? 3'd3 : 3'd0) + (sens_q[1] ? 3'd1 : 3'd0);
		neg = w_neg > w_pos;
		mag = neg ? (w_neg - w_pos) : (w_pos - w_neg);
		// Round the weighted sum over the active count to nearest
		unique case (n_act)
			3'd1: q = Q_W'(mag) << FRAC_BITS;
			3'd2: q = Q_W'(mag) << (FRAC_BITS - 1);
			3'd3: q = (mag == 3'd1) ? ERR_THIRD : ERR_ONE;
			default: q = '0;
		endcase
		q_s = $signed({1'b0, q});
		if (n_act == 3'd0) err_new = prev_err_q;
		else err_new = neg ? -q_s : q_s;
		// Accumulate and clamp the integral
		integ_sum = (I_W+1)'(integ_q) + (I_W+1)'(err_new);
		if (integ_sum > INT_HI) integ_nxt = I_W'(INT_HI);
		else if (integ_sum < INT_LO) integ_nxt = I_W'(INT_LO);
		else integ_nxt = I_W'(integ_sum);
		count_nxt = (count_q == COUNT_W'(COUNT_MAX)) ? count_q : count_q + 1'b1;
		stop = count_nxt >= target_q;
	end

	assign sts.cross_evt = cross_evt;

	// Shared multiplier: gain times signed operand
	always_comb begin
		priority if (cmd.mul_p) begin
			mul_a = prop_gain_q;
			mul_b = I_W'(err_q);
		end else if (cmd.mul_i) begin
			mul_a = integ_gain_q;
			mul_b = integ_q;
		end else begin
			mul_a = deriv_gain_q;
			mul_b = I_W'(diff_q);
		end
	end

	assign mul_y = $signed({1'b0, mul_a}) * mul_b;

	assign base_ext = $signed({{(A_W - SPEED_W - SH){1'b0}}, base_speed_q, {SH{1'b0}}});
	assign v_left   = base_ext + acc_q;
	assign v_right  = base_ext - acc_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			base_speed_q <= BASE_SPEED_RST;
			target_q     <= TARGET_CROSS_RST;
		end else if (cfg.en) begin
			unique case (cfg.idx)
				REG_PROP_GAIN:    prop_gain_q  <= cfg.data;
				REG_INTEG_GAIN:   integ_gain_q <= cfg.data;
				REG_DERIV_GAIN:   deriv_gain_q <= cfg.data;
				REG_BASE_SPEED:   base_speed_q <= cfg.data[SPEED_W-1:0];
				REG_TARGET_CROSS: target_q     <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Loop state update at evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
			on_cross_q <= 1'b0;
			count_q    <= '0;
		end else if (cmd.eval) begin
			if (cross_evt) begin
				on_cross_q <= 1'b1;
				count_q    <= count_nxt;
				// Pass clears the loop, stop leaves it
				if (!stop) begin
					integ_q    <= '0;
					prev_err_q <= '0;
				end
			end else begin
				if (!cross_hit) on_cross_q <= 1'b0;
				integ_q    <= integ_nxt;
				prev_err_q <= err_new;
			end
		end
	end

	// Work and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) sens_q <= sens;
		if (cmd.eval) begin
			err_q  <= err_new;
			diff_q <= D_W'(err_new) - D_W'(prev_err_q);
			if (cross_evt) begin
				res_count_q <= count_nxt;
				if (stop) begin
					res_action_q <= ACT_STOP;
					res_left_q   <= '0;
					res_right_q  <= '0;
				end else begin
					res_action_q <= ACT_PASS;
					res_left_q   <= SPEED_W'(PASS_SPEED);
					res_right_q  <= SPEED_W'(PASS_SPEED);
				end
			end else begin
				res_count_q  <= count_q;
				res_action_q <= ACT_DRIVE;
			end
		end
		if (cmd.mul_p || cmd.mul_i || cmd.mul_d) prod_q <= mul_y;
		if (cmd.mul_i) acc_q <= A_W'(prod_q);
		if (cmd.mul_d || cmd.sum) acc_q <= acc_q + A_W'(prod_q);
		if (cmd.speed) begin
			res_left_q  <= clamp_speed(v_left);
			res_right_q <= clamp_speed(v_right);
		end
		if (cmd.load_out) begin
			out_action_q <= res_action_q;
			out_left_q   <= res_left_q;
			out_right_q  <= res_right_q;
			out_count_q  <= res_count_q;
		end
	end

	assign out_action = out_action_q;
	assign out_left   = out_left_q;
	assign out_right  = out_right_q;
	assign out_count  = out_count_q;

endmodule

### hdl/line_follower_pid_steering.sv
`timescale 1ns / 1ps
// Channel  Signals                               Word
// -------  ------------------------------------  ----------------------------------------
// s_       s_tvalid s_tready s_tdata[7:0]         four sensor bits, outer left at bit 0
// m_       m_tvalid m_tready m_tdata[23:0] tuser  speeds and crossing count, action in tuser
// cfg_     cfg_valid cfg_ready cfg_index cfg_data register write, always ready
//
// A drive word runs from accept to the next accept through one evaluation step,
// three passes through the single shared multiplier, one sum, one speed clamp, one
// output load. A crossing answer goes from evaluation straight to the output load.
// arst_n clears the loop state, crossing count and handshake flags; registers take defaults.
// A stalled output word holds while a new sample is accepted; the next result waits for it.

module line_follower_pid_steering
	import lfps_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // outer_left_seen, inner_left_seen,
	                                          // inner_right_seen, outer_right_seen, pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,    // left motor speed, right motor speed,
	                                          // crossings_seen
	output logic [1:0]            m_tuser,    // action
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_wr_t            cfg;
	cmd_t               cmd;
	sts_t               sts;
	action_t            out_action;
	logic [SPEED_W-1:0] out_left, out_right;
	logic [COUNT_W-1:0] out_count;

	assign cfg_ready = 1'b1;
	assign cfg.en    = cfg_valid;
	assign cfg.idx   = cfg_index;
	assign cfg.data  = cfg_data;

	lfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfps_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.sens       (s_tdata[3:0]),
		.cmd        (cmd),
		.sts        (sts),
		.out_action (out_action),
		.out_left   (out_left),
		.out_right  (out_right),
		.out_count  (out_count)
	);

	assign m_tdata = {out_count, out_right, out_left};
	assign m_tuser = out_action;

endmodule

### hdl/lfps_chk.sv
`timescale 1ns / 1ps

module lfps_chk
	import lfps_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// Stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// One sample in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted during evaluation");

	// Drive speeds stay inside the clamp window
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_DRIVE |->
			m_tdata[7:0] >= 8'(SPEED_MIN) && m_tdata[7:0] <= 8'(SPEED_MAX) &&
			m_tdata[15:8] >= 8'(SPEED_MIN) && m_tdata[15:8] <= 8'(SPEED_MAX))
		else $error("drive speed out of range");

	// Pass goes straight at pass speed
	a_pass_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_PASS |->
			m_tdata[7:0] == 8'(PASS_SPEED) && m_tdata[15:8] == 8'(PASS_SPEED))
		else $error("pass speed wrong");

	// Stop halts both motors after at least one crossing
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_STOP |->
			m_tdata[15:0] == 16'd0 && m_tdata[23:16] != 8'd0)
		else $error("stop word wrong");

endmodule

bind line_follower_pid_steering lfps_chk u_lfps_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### verif/line_follower_pid_steering_tb.sv
`timescale 1ns / 1ps

module line_follower_pid_steering_tb;
	import lfps_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint ONE_E = longint'(1) << FRAC;
	localparam longint SCALE_S = longint'(1) << (GAIN_FRAC + FRAC);
	localparam longint INTEG_CAP = INTEG_LIMIT * ONE_E;
	localparam int REG_SPAN = 5;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RUN_LIMIT_NS = 5_000_000;

	typedef struct packed {
		action_t    action;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] count;
	} steer_word_t;

	typedef struct packed {
		bit          fixed;
		steer_word_t word;
	} pin_t;

	typedef struct {
		logic [3:0]  seen;     // outer right, inner right, inner left, outer left
		int          retarget; // new target before this row, -1 keeps it
		bit          fixed;
		steer_word_t word;
	} probe_row_t;

	localparam steer_word_t ANY_WORD = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;    // outer_left_seen, inner_left_seen, inner_right_seen,
	                             // outer_right_seen, pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;        // left motor speed, right motor speed, crossings_seen
	logic [1:0] m_tuser;         // action
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the steering registers and loop state
	logic [GAIN_W-1:0] prop_reg = PROP_GAIN_RST;
	logic [GAIN_W-1:0] integ_reg = INTEG_GAIN_RST;
	logic [GAIN_W-1:0] deriv_reg = DERIV_GAIN_RST;
	logic [SPEED_W-1:0] base_reg = BASE_SPEED_RST;
	logic [COUNT_W-1:0] target_reg = TARGET_CROSS_RST;
	longint integ_acc = 0;
	longint last_err = 0;
	bit on_cross = 1'b0;
	int cross_cnt = 0;

	steer_word_t steer_q[$];
	pin_t pinned_q[$];
	int bad_words = 0;
	int shown = 0;
	int send_idle = 12;
	int recv_idle = 87;
	int stall_reqs = 0;
	int stall_served = 0;
	int hold_left = 0;

	probe_row_t probe [0:22] = '{
		'{4'b0000, -1, 1'b1, '{ACT_DRIVE, 8'd125, 8'd125, 8'd0}},
		'{4'b1111, -1, 1'b1, '{ACT_STOP, 8'd0, 8'd0, 8'd1}},
		'{4'b1111, -1, 1'b0, ANY_WORD},
		'{4'b1000, -1, 1'b0, ANY_WORD},
		'{4'b0000, -1, 1'b0, ANY_WORD},
		'{4'b0001, -1, 1'b0, ANY_WORD},
		'{4'b0010, -1, 1'b0, ANY_WORD},
		'{4'b0100, -1, 1'b0, ANY_WORD},
		'{4'b1100, -1, 1'b0, ANY_WORD},
		'{4'b0011, -1, 1'b0, ANY_WORD},
		'{4'b0110, -1, 1'b0, ANY_WORD},
		'{4'b1001, -1, 1'b0, ANY_WORD},
		'{4'b1010, -1, 1'b0, ANY_WORD},
		'{4'b0101, -1, 1'b0, ANY_WORD},
		'{4'b0111, -1, 1'b1, '{ACT_STOP, 8'd0, 8'd0, 8'd2}},
		'{4'b1110, -1, 1'b0, ANY_WORD},
		'{4'b0000, 255, 1'b0, ANY_WORD},
		'{4'b1011, -1, 1'b1, '{ACT_PASS, 8'd180, 8'd180, 8'd3}},
		'{4'b1101, -1, 1'b0, ANY_WORD},
		'{4'b1000, -1, 1'b0, ANY_WORD},
		'{4'b1111, 0, 1'b1, '{ACT_STOP, 8'd0, 8'd0, 8'd4}},
		'{4'b1111, -1, 1'b0, ANY_WORD},
		'{4'b0000, -1, 1'b0, ANY_WORD}
	};

	line_follower_pid_steering dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Clamp a Q.S speed to the motor range and drop the fraction
	function automatic logic [7:0] speed_clamp(input longint v);
		if (v < SPEED_MIN * SCALE_S)
			return 8'(SPEED_MIN);
		if (v > SPEED_MAX * SCALE_S)
			return 8'(SPEED_MAX);
		return 8'(v / SCALE_S);
	endfunction

	// Advance the steering state by one sensor sample and return its word
	function automatic steer_word_t steer_predict(input logic [3:0] seen);
		steer_word_t r;
		int n;
		longint w, mag, q, err, corr, pg, ig, dg, base_q;
		r = ANY_WORD;
		n = $countones(seen);
		if (n > 2 && !on_cross) begin
			on_cross = 1'b1;
			if (cross_cnt < COUNT_MAX)
				cross_cnt++;
			if (cross_cnt >= int'(target_reg)) begin
				r.action = ACT_STOP;
			end else begin
				r.action = ACT_PASS;
				r.left = 8'(PASS_SPEED);
				r.right = 8'(PASS_SPEED);
				integ_acc = 0;
				last_err = 0;
			end
			r.count = 8'(cross_cnt);
			return r;
		end
		if (n <= 2)
			on_cross = 1'b0;
		// weighted position: outer sensors count three, inner ones one
		if (n > 0) begin
			w = 3 * (longint'(seen[3]) - longint'(seen[0])) + longint'(seen[2]) - longint'(seen[1]);
			mag = (w < 0) ? -w : w;
			q = (mag * 2 * ONE_E + n) / (2 * n);
			err = (w < 0) ? -q : q;
		end else begin
			err = last_err;
		end
		integ_acc += err;
		if (integ_acc > INTEG_CAP)
			integ_acc = INTEG_CAP;
		if (integ_acc < -INTEG_CAP)
			integ_acc = -INTEG_CAP;
		pg = prop_reg;
		ig = integ_reg;
		dg = deriv_reg;
		corr = pg * err + ig * integ_acc + dg * (err - last_err);
		last_err = err;
		base_q = longint'(base_reg) * SCALE_S;
		r.action = ACT_DRIVE;
		r.left = speed_clamp(base_q + corr);
		r.right = speed_clamp(base_q - corr);
		r.count = 8'(cross_cnt);
		return r;
	endfunction

	// Track register writes, predict accepted samples, check returned words
	always @(posedge clk) begin : watch
		steer_word_t want, got;
		pin_t pin;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.action = action_t'(m_tuser);
				got.left = m_tdata[7:0];
				got.right = m_tdata[15:8];
				got.count = m_tdata[23:16];
				if (steer_q.size() == 0) begin
					bad_words++;
					if (shown < 10) begin
						shown++;
						$display("%0t unexpected word: action %0d left %0d right %0d count %0d",
							$time, got.action, got.left, got.right, got.count);
					end
				end else begin
					want = steer_q.pop_front();
					if (got != want) begin
						bad_words++;
						if (shown < 10) begin
							shown++;
							$display("%0t mismatch: expected action %0d left %0d right %0d count %0d",
								$time, want.action, want.left, want.right, want.count);
							$display("%0t            got action %0d left %0d right %0d count %0d",
								$time, got.action, got.left, got.right, got.count);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = steer_predict(s_tdata[3:0]);
				pin = pinned_q.pop_front();
				if (pin.fixed)
					want = pin.word;
				steer_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN: prop_reg = cfg_data;
					REG_INTEG_GAIN: integ_reg = cfg_data;
					REG_DERIV_GAIN: deriv_reg = cfg_data;
					REG_BASE_SPEED: base_reg = cfg_data[7:0];
					REG_TARGET_CROSS: target_reg = cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// Drive output backpressure; a hold request blocks the output for a long stretch
	always @(posedge clk) begin
		if (stall_served != stall_reqs) begin
			stall_served <= stall_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_sample(input logic [3:0] seen, input bit fixed, input steer_word_t word);
		pinned_q.push_back('{fixed, word});
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {4'b0000, seen};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop offering samples and wait for every outstanding word
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int i = 0; i < DRAIN_LIMIT && steer_q.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Load all five registers plus one unused index; junk rides in the upper byte
	task automatic program_regs(input logic [15:0] pg, input logic [15:0] ig,
		input logic [15:0] dg, input logic [7:0] bs, input logic [7:0] tc);
		drain();
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_DERIV_GAIN, dg);
		write_reg(REG_BASE_SPEED, {8'($urandom), bs});
		write_reg(REG_TARGET_CROSS, {8'($urandom), tc});
		write_reg(CFG_IDX_W'(REG_SPAN + $urandom_range(2)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [3:0] line_pick();
		logic [3:0] p;
		do
			p = 4'($urandom_range(15));
		while ($countones(p) > 2);
		return p;
	endfunction

	function automatic logic [3:0] cross_pick();
		logic [3:0] p;
		do
			p = 4'($urandom_range(15));
		while ($countones(p) < 3);
		return p;
	endfunction

	// Stretches of line tracking broken by crossings, with some stray samples
	task automatic run_track(input int items, input int line_max, input bit hold_line,
		input bit squeeze, input bit pause);
		int sent;
		int run;
		bit mid_done;
		logic [3:0] pick;
		sent = 0;
		mid_done = 1'b0;
		while (sent < items) begin
			run = $urandom_range(line_max, 1);
			pick = line_pick();
			repeat (run) begin
				if (!hold_line)
					pick = line_pick();
				send_sample(pick, 1'b0, ANY_WORD);
				sent++;
			end
			run = $urandom_range(2, 1);
			repeat (run) begin
				send_sample(cross_pick(), 1'b0, ANY_WORD);
				sent++;
			end
			if ($urandom_range(99) < 10) begin
				send_sample(4'($urandom_range(15)), 1'b0, ANY_WORD);
				sent++;
			end
			if (!mid_done && sent >= items / 2) begin
				mid_done = 1'b1;
				if (squeeze)
					stall_reqs <= stall_reqs + 1;
				if (pause)
					drain();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows on reset settings, retargeting where a row asks
		foreach (probe[i]) begin
			if (probe[i].retarget >= 0) begin
				drain();
				write_reg(REG_TARGET_CROSS, CFG_DATA_W'(probe[i].retarget));
				cfg_valid <= 1'b0;
			end
			send_sample(probe[i].seen, probe[i].fixed, probe[i].word);
		end

		// modest gains, target out of reach so crossings pass
		program_regs(16'($urandom_range(4096)), 16'($urandom_range(512)),
			16'($urandom_range(4096)), 8'd125, 8'd255);
		run_track(170, 3, 1'b0, 1'b0, 1'b0);

		// any gains and target, with a long output hold
		program_regs(16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom_range(255)));
		run_track(170, 3, 1'b0, 1'b1, 1'b0);

		send_idle = 87;
		recv_idle = 12;
		// all gains and base at the top, pause for a full drain midway
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
		run_track(170, 3, 1'b0, 1'b0, 1'b1);

		// zero base and target, crossings packed close to saturate the count
		program_regs(16'd0, 16'($urandom), 16'd0, 8'd0, 8'd0);
		run_track(290, 1, 1'b0, 1'b1, 1'b0);

		send_idle = 0;
		recv_idle = 0;
		// long runs to one side drive the integral into its clamp
		program_regs(16'd512, 16'd64, 16'd2048, 8'd128, 8'($urandom_range(255)));
		run_track(150, 40, 1'b1, 1'b0, 1'b0);

		drain();
		bad_words += steer_q.size();
		if (bad_words == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### line_follower_pid_steering.f
hdl/lfps_pkg.sv
hdl/lfps_ctrl.sv
hdl/lfps_dp.sv
hdl/line_follower_pid_steering.sv
hdl/lfps_chk.sv
verif/line_follower_pid_steering_tb.sv
